// ===== rtl/core/column_zone_map_pruner_defines.svh =====
// Assertion macros shared by the checker files of the zone map pruner.
`ifndef COLUMN_ZONE_MAP_PRUNER_DEFINES_SVH
`define COLUMN_ZONE_MAP_PRUNER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CZMP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define CZMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/czmp_pkg.sv =====
// Package with types, codes and field positions of the zone map pruner.
`default_nettype none

package czmp_pkg;

   // Default sizes.
   localparam int COLUMNS_DEFAULT    = 64;
   localparam int COUNT_BITS_DEFAULT = 32;

   // Field widths.
   localparam int FUNC_W  = 2;
   localparam int COL_W   = 6;
   localparam int VALUE_W = 64;
   localparam int OP_W    = 4;
   localparam int CFG_W   = 7;

   // Input item packing in req_tdata.
   localparam int REQ_COL_LO  = 0;
   localparam int REQ_A_LO    = REQ_COL_LO + COL_W;
   localparam int REQ_B_LO    = REQ_A_LO + VALUE_W;
   localparam int REQ_OP_LO   = REQ_B_LO + VALUE_W;
   localparam int REQ_NUM_BIT = REQ_OP_LO + OP_W;
   localparam int REQ_TDATA_W = 144;

   // Result item packing in rsp_tdata.
   localparam int RSP_VERDICT_BIT = 0;
   localparam int RSP_SKIP_BIT    = 1;
   localparam int RSP_DIRTY_BIT   = 2;
   localparam int RSP_TDATA_W     = 8;

   // Reset value of the column count register.
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // Extremes of the signed Q32.32 range.
   localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

   // Item kinds.
   localparam logic [FUNC_W-1:0] FUNC_VALUE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NULL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_ELEM  = 2'd3;

   // Predicate codes.
   localparam logic [OP_W-1:0] OP_EQ       = 4'd0;
   localparam logic [OP_W-1:0] OP_NE       = 4'd1;
   localparam logic [OP_W-1:0] OP_GT       = 4'd2;
   localparam logic [OP_W-1:0] OP_GE       = 4'd3;
   localparam logic [OP_W-1:0] OP_LT       = 4'd4;
   localparam logic [OP_W-1:0] OP_LE       = 4'd5;
   localparam logic [OP_W-1:0] OP_BETWEEN  = 4'd6;
   localparam logic [OP_W-1:0] OP_NBETWEEN = 4'd7;
   localparam logic [OP_W-1:0] OP_IN       = 4'd8;
   localparam logic [OP_W-1:0] OP_IS_NULL  = 4'd10;
   localparam logic [OP_W-1:0] OP_NOT_NULL = 4'd11;

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;  // write reset values at the sweep address
      logic load;      // capture the input item and read its column entry
      logic commit;    // write back, update flags and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // sweep is at the last entry
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/column_zone_map_pruner.sv =====
// Top level of the column zone map pruner.
`default_nettype none

// Keeps min, max, saturating sum, value count, null count and a has-null mark
// for each column in one statistics memory, and answers whether a data unit
// can be skipped for a one-column predicate or an IN list sent one element
// per item. Items are worked one at a time: each is accepted and its column's
// entry read from the statistics memory, then evaluated, the entry written
// back and the result register loaded; a full result register that is not
// drained holds the item until it is. After reset a clearing pass writes the
// reset entry to every column, during which no item is accepted; configuration
// writes are taken at any time.

module column_zone_map_pruner #(
   parameter int COLUMNS    = czmp_pkg::COLUMNS_DEFAULT,
   parameter int COUNT_BITS = czmp_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // column, operand_a, operand_b, op, numeric_operand, zero padding
   input  wire logic [czmp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // func
   input  wire logic [czmp_pkg::FUNC_W-1:0]       req_tuser,
   input  wire logic                              req_tlast,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // verdict_valid, can_skip, dirty, zero padding
   output logic      [czmp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [czmp_pkg::CFG_W-1:0]        csr_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready
);

   czmp_pkg::cmd_type    cmd;
   czmp_pkg::status_type status;

   czmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   czmp_datapath #(
      .COLUMNS    (COLUMNS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// ===== rtl/core/czmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module czmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/czmp_ctrl.sv =====
// Controller state machine: clearing sweep, item acceptance and result hand-off.
`default_nettype none

module czmp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire czmp_pkg::status_type  status,
   output czmp_pkg::cmd_type          cmd
);

   czmp_pkg::ctrl_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         czmp_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = czmp_pkg::ST_IDLE;
            end
         end
         czmp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = czmp_pkg::ST_EXEC;
            end
         end
         czmp_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in = czmp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = czmp_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_tready   = 1'b0;
      cmd.clear_wr = 1'b0;
      cmd.load     = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         czmp_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         czmp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         czmp_pkg::ST_EXEC: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd.clear_wr = 1'b0;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= czmp_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/czmp_datapath.sv =====
// Datapath: statistics memory, predicate evaluation and result register.
`default_nettype none

module czmp_datapath #(
   parameter int COLUMNS    = czmp_pkg::COLUMNS_DEFAULT,
   parameter int COUNT_BITS = czmp_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [czmp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic [czmp_pkg::FUNC_W-1:0]         req_tuser,
   input  wire logic                                req_tlast,
   output logic      [czmp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [czmp_pkg::CFG_W-1:0]          csr_data,
   input  wire czmp_pkg::cmd_type                   cmd,
   output czmp_pkg::status_type                     status
);

   localparam int VW     = czmp_pkg::VALUE_W;
   localparam int ADDR_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int XW     = (ADDR_W > czmp_pkg::COL_W) ? ADDR_W : czmp_pkg::COL_W;

   // Entry layout: min, max, sum, value count, null count, has-null mark.
   localparam int MIN_LO  = 0;
   localparam int MAX_LO  = MIN_LO + VW;
   localparam int SUM_LO  = MAX_LO + VW;
   localparam int ROW_LO  = SUM_LO + VW;
   localparam int NUL_LO  = ROW_LO + COUNT_BITS;
   localparam int SEEN_B  = NUL_LO + COUNT_BITS;
   localparam int ENTRY_W = SEEN_B + 1;

   logic [czmp_pkg::CFG_W-1:0]  cols_ff;
   logic [ADDR_W-1:0]           clr_addr_ff;
   logic [czmp_pkg::FUNC_W-1:0] func_ff;
   logic [czmp_pkg::COL_W-1:0]  col_ff;
   logic signed [VW-1:0]        a_ff;
   logic signed [VW-1:0]        b_ff;
   logic [czmp_pkg::OP_W-1:0]   op_ff;
   logic                        num_ff;
   logic                        last_ff;
   logic                        dirty_ff, dirty_in;
   logic                        list_hit_ff, list_hit_in;
   logic [czmp_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   logic [XW-1:0]        req_col_x;
   logic [XW-1:0]        col_x;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 wr_en;
   logic [ENTRY_W-1:0]   rd_data;
   logic [ENTRY_W-1:0]   entry_new;

   logic signed [VW-1:0]  mn, mx, sum, sum_raw;
   logic [COUNT_BITS-1:0] rows, nulls;
   logic                  seen;
   logic                  col_ok, usable, is_record;
   logic                  a_lt_mn, a_gt_mn, a_lt_mx, a_gt_mx, mn_eq_mx, mn_eq_a;
   logic                  mn_gt_b, mx_le_b;
   logic                  test_skip, elem_hit, hit_total;
   logic                  verdict, skip;

   // Configuration register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= czmp_pkg::CFG_RESET;
      end else if (csr_valid) begin
         cols_ff <= csr_data;
      end
   end

   // Clearing sweep address.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign status.clear_last = (clr_addr_ff == ADDR_W'(COLUMNS - 1));

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser;
         col_ff  <= req_tdata[czmp_pkg::REQ_COL_LO +: czmp_pkg::COL_W];
         a_ff    <= req_tdata[czmp_pkg::REQ_A_LO +: VW];
         b_ff    <= req_tdata[czmp_pkg::REQ_B_LO +: VW];
         op_ff   <= req_tdata[czmp_pkg::REQ_OP_LO +: czmp_pkg::OP_W];
         num_ff  <= req_tdata[czmp_pkg::REQ_NUM_BIT];
         last_ff <= req_tlast;
      end
   end

   // Memory addressing: the column number is widened or cut to the depth.
   assign req_col_x = XW'(req_tdata[czmp_pkg::REQ_COL_LO +: czmp_pkg::COL_W]);
   assign col_x     = XW'(col_ff);
   assign rd_addr   = req_col_x[ADDR_W-1:0];
   assign wr_addr   = cmd.clear_wr ? clr_addr_ff : col_x[ADDR_W-1:0];

   czmp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (COLUMNS)
   ) u_stats_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (entry_new),
      .rd_en   (cmd.load),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Unpack the column entry.
   assign mn    = rd_data[MIN_LO +: VW];
   assign mx    = rd_data[MAX_LO +: VW];
   assign sum   = rd_data[SUM_LO +: VW];
   assign rows  = rd_data[ROW_LO +: COUNT_BITS];
   assign nulls = rd_data[NUL_LO +: COUNT_BITS];
   assign seen  = rd_data[SEEN_B];

   // Column validity against the register and the memory depth.
   assign col_ok    = ({1'b0, col_ff} < cols_ff) && (32'(col_ff) < 32'(COLUMNS));
   assign usable    = col_ok && num_ff;
   assign is_record = (func_ff == czmp_pkg::FUNC_VALUE) || (func_ff == czmp_pkg::FUNC_NULL);

   // Signed comparisons against the stored extremes.
   assign a_lt_mn  = a_ff < mn;
   assign a_gt_mn  = a_ff > mn;
   assign a_lt_mx  = a_ff < mx;
   assign a_gt_mx  = a_ff > mx;
   assign mn_eq_mx = mn == mx;
   assign mn_eq_a  = mn == a_ff;
   assign mn_gt_b  = mn > b_ff;
   assign mx_le_b  = mx <= b_ff;

   // Predicate decoder.
   always_comb begin
      unique case (op_ff)
         czmp_pkg::OP_EQ:       test_skip = a_lt_mn || a_gt_mx;
         czmp_pkg::OP_NE:       test_skip = mn_eq_mx && mn_eq_a;
         czmp_pkg::OP_GT:       test_skip = !a_lt_mx;
         czmp_pkg::OP_GE:       test_skip = a_gt_mx;
         czmp_pkg::OP_LT:       test_skip = !a_gt_mn;
         czmp_pkg::OP_LE:       test_skip = a_lt_mn;
         czmp_pkg::OP_BETWEEN:  test_skip = a_gt_mx || mn_gt_b;
         czmp_pkg::OP_NBETWEEN: test_skip = !a_gt_mn && mx_le_b;
         czmp_pkg::OP_IN:       test_skip = a_lt_mn || a_gt_mx;
         czmp_pkg::OP_IS_NULL:  test_skip = !seen;
         czmp_pkg::OP_NOT_NULL: test_skip = (rows == '0) && (nulls != '0);
         default:               test_skip = 1'b0;
      endcase
   end

   // IN-list element: an unusable element or one inside the range is a hit.
   assign elem_hit  = !usable || (!a_lt_mn && !a_gt_mx);
   assign hit_total = list_hit_ff || elem_hit;

   // Verdict of the current item.
   always_comb begin
      verdict = 1'b0;
      skip    = 1'b0;
      case (func_ff)
         czmp_pkg::FUNC_TEST: begin
            verdict = 1'b1;
            skip    = usable && test_skip;
         end
         czmp_pkg::FUNC_ELEM: begin
            verdict = last_ff;
            skip    = last_ff && (op_ff == czmp_pkg::OP_IN) && !hit_total;
         end
         default: begin
            verdict = 1'b0;
         end
      endcase
   end

   // Updated entry, or the reset entry during the sweep.
   always_comb begin
      entry_new = rd_data;
      sum_raw   = sum + a_ff;
      if (cmd.clear_wr) begin
         entry_new[MIN_LO +: VW]         = czmp_pkg::VALUE_MAX;
         entry_new[MAX_LO +: VW]         = czmp_pkg::VALUE_MIN;
         entry_new[SUM_LO +: VW]         = '0;
         entry_new[ROW_LO +: COUNT_BITS] = '0;
         entry_new[NUL_LO +: COUNT_BITS] = '0;
         entry_new[SEEN_B]               = 1'b0;
      end else if (func_ff == czmp_pkg::FUNC_VALUE) begin
         entry_new[MIN_LO +: VW] = a_lt_mn ? a_ff : mn;
         entry_new[MAX_LO +: VW] = a_gt_mx ? a_ff : mx;
         // Saturate when both addends share a sign that the sum lost.
         if ((sum[VW-1] == a_ff[VW-1]) && (sum_raw[VW-1] != a_ff[VW-1])) begin
            entry_new[SUM_LO +: VW] = a_ff[VW-1] ? czmp_pkg::VALUE_MIN : czmp_pkg::VALUE_MAX;
         end else begin
            entry_new[SUM_LO +: VW] = sum_raw;
         end
         entry_new[ROW_LO +: COUNT_BITS] = (&rows) ? rows : rows + 1'b1;
      end else begin
         entry_new[NUL_LO +: COUNT_BITS] = (&nulls) ? nulls : nulls + 1'b1;
         entry_new[SEEN_B]               = 1'b1;
      end
   end

   assign wr_en = cmd.clear_wr || (cmd.commit && col_ok && is_record);

   // Dirty and IN-list flags.
   always_comb begin
      dirty_in    = dirty_ff;
      list_hit_in = list_hit_ff;
      if (cmd.commit) begin
         if (col_ok && is_record) begin
            dirty_in = 1'b1;
         end
         if (func_ff == czmp_pkg::FUNC_ELEM) begin
            list_hit_in = last_ff ? 1'b0 : hit_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff    <= 1'b0;
         list_hit_ff <= 1'b0;
      end else begin
         dirty_ff    <= dirty_in;
         list_hit_ff <= list_hit_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff                            <= '0;
         rsp_data_ff[czmp_pkg::RSP_VERDICT_BIT] <= verdict;
         rsp_data_ff[czmp_pkg::RSP_SKIP_BIT]    <= skip;
         rsp_data_ff[czmp_pkg::RSP_DIRTY_BIT]   <= dirty_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/czmp_checker.sv =====
// Port-level checker for the zone map pruner and its bind statement.
`default_nettype none

`include "column_zone_map_pruner_defines.svh"

module czmp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [czmp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready
);

   logic dirty_seen_ff;

   // Remember that a delivered item has reported dirty statistics.
   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[czmp_pkg::RSP_DIRTY_BIT]) begin
         dirty_seen_ff <= 1'b1;
      end
   end

   // A stalled result holds its data.
   `CZMP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // A skip is only reported together with a verdict.
   `CZMP_ASSERT(a_skip_verdict, !rsp_tvalid || !rsp_tdata[czmp_pkg::RSP_SKIP_BIT] || rsp_tdata[czmp_pkg::RSP_VERDICT_BIT], "skip without verdict")

   // Dirty never clears once reported.
   `CZMP_ASSERT(a_dirty_sticky, !(rsp_tvalid && dirty_seen_ff) || rsp_tdata[czmp_pkg::RSP_DIRTY_BIT], "dirty flag cleared")

   // Items are worked one at a time: no acceptance in the cycle after one.
   `CZMP_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "input accepted back to back")

endmodule

bind column_zone_map_pruner czmp_checker u_czmp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

// ===== verif/column_zone_map_pruner_tb.sv =====
// Self-checking testbench for the column zone map pruner: directed rows, then random streams.
module column_zone_map_pruner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_HALF    = 6;
   localparam int          RESET_CYCLES  = 3;
   localparam int          ITEM_TARGET   = 1950;
   localparam int          SEGMENTS      = 6;
   localparam int          HOLD_CYCLES   = 200;
   localparam int          SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int          COLUMNS       = czmp_pkg::COLUMNS_DEFAULT;
   localparam int          DIR_N         = 26;

   // Local copies of the field widths.
   localparam int FUNC_W  = czmp_pkg::FUNC_W;
   localparam int COL_W   = czmp_pkg::COL_W;
   localparam int VALUE_W = czmp_pkg::VALUE_W;
   localparam int OP_W    = czmp_pkg::OP_W;
   localparam int CFG_W   = czmp_pkg::CFG_W;

   // Predicate codes that the package leaves unnamed.
   localparam logic [OP_W-1:0] OP_NOT_IN  = 4'd9;
   localparam logic [OP_W-1:0] OP_PATTERN = 4'd12;

   // Handy Q32.32 constants for the directed rows.
   localparam logic signed [VALUE_W-1:0] Q0 = 64'sd0;
   localparam logic signed [VALUE_W-1:0] Q1 = 64'sh1_0000_0000;
   localparam logic signed [VALUE_W-1:0] Q4 = 64'sh4_0000_0000;
   localparam logic signed [VALUE_W-1:0] Q5 = 64'sh5_0000_0000;
   localparam logic signed [VALUE_W-1:0] Q9 = 64'sh9_0000_0000;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [COL_W-1:0]          column;
      logic signed [VALUE_W-1:0] a;
      logic signed [VALUE_W-1:0] b;
      logic [OP_W-1:0]           op;
      logic                      numeric;
      logic                      last;
   } zone_item_type;

   typedef struct packed {
      logic verdict;
      logic skip;
      logic dirty;
   } zone_answer_type;

   typedef struct packed {
      zone_item_type   it;
      logic            typed;
      zone_answer_type answer;
   } dir_row_type;

   // Answers that can be typed in directly.
   localparam zone_answer_type ANS_PREDICT    = '{1'b0, 1'b0, 1'b0};
   localparam zone_answer_type ANS_SKIP_CLEAN = '{1'b1, 1'b1, 1'b0};
   localparam zone_answer_type ANS_KEEP_CLEAN = '{1'b1, 1'b0, 1'b0};
   localparam zone_answer_type ANS_KEEP_DIRTY = '{1'b1, 1'b0, 1'b1};
   localparam zone_answer_type ANS_NO_VERDICT = '{1'b0, 1'b0, 1'b1};

   // Directed rows: empty column, extremes with saturation, every predicate, IN lists.
   dir_row_type dir_rows [DIR_N] = '{
      '{'{czmp_pkg::FUNC_TEST, 6'd0, Q0, Q0, czmp_pkg::OP_EQ, 1'b1, 1'b0},
        1'b1, ANS_SKIP_CLEAN},
      '{'{czmp_pkg::FUNC_TEST, 6'd0, Q0, Q0, czmp_pkg::OP_IS_NULL, 1'b1, 1'b0},
        1'b1, ANS_SKIP_CLEAN},
      '{'{czmp_pkg::FUNC_TEST, 6'd0, Q0, Q0, czmp_pkg::OP_NOT_NULL, 1'b1, 1'b0},
        1'b1, ANS_KEEP_CLEAN},
      '{'{czmp_pkg::FUNC_VALUE, 6'd0, czmp_pkg::VALUE_MAX, Q0, czmp_pkg::OP_EQ, 1'b1, 1'b0},
        1'b1, ANS_NO_VERDICT},
      '{'{czmp_pkg::FUNC_VALUE, 6'd0, czmp_pkg::VALUE_MAX, Q0, czmp_pkg::OP_EQ, 1'b1, 1'b0},
        1'b1, ANS_NO_VERDICT},
      '{'{czmp_pkg::FUNC_VALUE, 6'd0, czmp_pkg::VALUE_MIN, Q0, czmp_pkg::OP_EQ, 1'b1, 1'b0},
        1'b1, ANS_NO_VERDICT},
      '{'{czmp_pkg::FUNC_VALUE, 6'd1, czmp_pkg::VALUE_MIN, Q0, czmp_pkg::OP_EQ, 1'b1, 1'b0},
        1'b1, ANS_NO_VERDICT},
      '{'{czmp_pkg::FUNC_VALUE, 6'd1, czmp_pkg::VALUE_MIN, Q0, czmp_pkg::OP_EQ, 1'b1, 1'b0},
        1'b1, ANS_NO_VERDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd0, Q0, Q0, czmp_pkg::OP_EQ, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_VALUE, 6'd2, Q5, Q0, czmp_pkg::OP_EQ, 1'b1, 1'b0},
        1'b1, ANS_NO_VERDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q5, Q0, czmp_pkg::OP_NE, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q5, Q0, czmp_pkg::OP_GT, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q5, Q0, czmp_pkg::OP_GE, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q5, Q0, czmp_pkg::OP_LT, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q5, Q0, czmp_pkg::OP_LE, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q1, Q4, czmp_pkg::OP_BETWEEN, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q1, Q9, czmp_pkg::OP_NBETWEEN, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q1, Q0, czmp_pkg::OP_IN, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_NULL, 6'd3, Q0, Q0, czmp_pkg::OP_EQ, 1'b1, 1'b0},
        1'b1, ANS_NO_VERDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd3, Q0, Q0, czmp_pkg::OP_NOT_NULL, 1'b1, 1'b0},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q5, Q0, OP_PATTERN, 1'b1, 1'b0},
        1'b1, ANS_KEEP_DIRTY},
      '{'{czmp_pkg::FUNC_TEST, 6'd2, Q5, Q0, czmp_pkg::OP_EQ, 1'b0, 1'b0},
        1'b1, ANS_KEEP_DIRTY},
      '{'{czmp_pkg::FUNC_ELEM, 6'd2, Q1, Q0, czmp_pkg::OP_IN, 1'b1, 1'b0},
        1'b1, ANS_NO_VERDICT},
      '{'{czmp_pkg::FUNC_ELEM, 6'd2, Q9, Q0, czmp_pkg::OP_IN, 1'b1, 1'b1},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_ELEM, 6'd2, Q5, Q0, OP_NOT_IN, 1'b1, 1'b1},
        1'b0, ANS_PREDICT},
      '{'{czmp_pkg::FUNC_TEST, 6'd63, czmp_pkg::VALUE_MIN, czmp_pkg::VALUE_MAX,
          czmp_pkg::OP_BETWEEN, 1'b1, 1'b0},
        1'b0, ANS_PREDICT}
   };

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic [czmp_pkg::REQ_TDATA_W-1:0]    req_tdata  = '0;
   logic [FUNC_W-1:0]                   req_tuser  = '0;
   logic                                req_tlast  = 1'b0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [czmp_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [CFG_W-1:0]                    csr_data   = czmp_pkg::CFG_RESET;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;

   // Predicted statistics, kept apart from the block's own memory.
   logic signed [VALUE_W-1:0] zone_min [COLUMNS];
   logic signed [VALUE_W-1:0] zone_max [COLUMNS];
   logic signed [VALUE_W-1:0] zone_sum [COLUMNS];
   logic [31:0]               value_count [COLUMNS];
   logic [31:0]               null_tally [COLUMNS];
   logic                      null_flag [COLUMNS];
   logic                      dirty_now    = 1'b0;
   logic                      list_hit_now = 1'b0;
   logic [CFG_W-1:0]          live_columns = czmp_pkg::CFG_RESET;

   zone_answer_type expected_q [$];
   zone_item_type   drive_item;
   logic            drive_typed = 1'b0;
   zone_answer_type drive_answer;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;
   int unsigned fail_count    = 0;

   column_zone_map_pruner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #CLOCK_HALF clock = ~clock;

   // Applies one accepted item to the predicted statistics and returns its answer.
   function automatic zone_answer_type zone_apply(zone_item_type it);
      zone_answer_type           ans;
      logic                      ok;
      logic signed [VALUE_W-1:0] a, b, mn, mx, sum;
      int unsigned               c;
      c   = 32'(it.column);
      ok  = (it.column < live_columns);
      a   = it.a;
      b   = it.b;
      mn  = zone_min[c];
      mx  = zone_max[c];
      ans = '0;
      case (it.func)
         czmp_pkg::FUNC_VALUE: begin
            if (ok) begin
               sum = zone_sum[c] + a;
               if (!zone_sum[c][VALUE_W-1] && !a[VALUE_W-1] && sum[VALUE_W-1])
                  sum = czmp_pkg::VALUE_MAX;
               else if (zone_sum[c][VALUE_W-1] && a[VALUE_W-1] && !sum[VALUE_W-1])
                  sum = czmp_pkg::VALUE_MIN;
               zone_sum[c] = sum;
               if (a < mn) zone_min[c] = a;
               if (a > mx) zone_max[c] = a;
               if (value_count[c] != '1) value_count[c] = value_count[c] + 32'd1;
               dirty_now = 1'b1;
            end
         end
         czmp_pkg::FUNC_NULL: begin
            if (ok) begin
               if (null_tally[c] != '1) null_tally[c] = null_tally[c] + 32'd1;
               null_flag[c] = 1'b1;
               dirty_now    = 1'b1;
            end
         end
         czmp_pkg::FUNC_TEST: begin
            ans.verdict = 1'b1;
            if (ok && it.numeric) begin
               case (it.op)
                  czmp_pkg::OP_EQ:       ans.skip = (a < mn) || (a > mx);
                  czmp_pkg::OP_NE:       ans.skip = (mn == mx) && (mn == a);
                  czmp_pkg::OP_GT:       ans.skip = (mx <= a);
                  czmp_pkg::OP_GE:       ans.skip = (mx < a);
                  czmp_pkg::OP_LT:       ans.skip = (mn >= a);
                  czmp_pkg::OP_LE:       ans.skip = (mn > a);
                  czmp_pkg::OP_BETWEEN:  ans.skip = (mx < a) || (mn > b);
                  czmp_pkg::OP_NBETWEEN: ans.skip = (mn >= a) && (mx <= b);
                  czmp_pkg::OP_IN:       ans.skip = !((a >= mn) && (a <= mx));
                  czmp_pkg::OP_IS_NULL:  ans.skip = !null_flag[c];
                  czmp_pkg::OP_NOT_NULL:
                     ans.skip = (value_count[c] == 0) && (null_tally[c] != 0);
                  default:               ans.skip = 1'b0;
               endcase
            end
         end
         default: begin
            // IN-list element: any possible match poisons the list.
            if (!(ok && it.numeric) || ((a >= mn) && (a <= mx))) list_hit_now = 1'b1;
            if (it.last) begin
               ans.verdict  = 1'b1;
               ans.skip     = (it.op == czmp_pkg::OP_IN) && !list_hit_now;
               list_hit_now = 1'b0;
            end
         end
      endcase
      ans.dirty = dirty_now;
      return ans;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9)) inside
         0:       v = czmp_pkg::VALUE_MAX;
         1:       v = czmp_pkg::VALUE_MIN;
         [2:3]:   ;
         default: v = v >>> $urandom_range(24, 44);
      endcase
      return v;
   endfunction

   // Targets cluster on the current bounds so both verdicts show up.
   function automatic logic signed [VALUE_W-1:0] pick_target(logic [COL_W-1:0] col);
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(7))
         0:       v = zone_min[col];
         1:       v = zone_max[col];
         2:       v = zone_min[col] - 1;
         3:       v = zone_max[col] + 1;
         default: v = pick_value();
      endcase
      return v;
   endfunction

   // Mostly a few hot columns, some at the edge of the live range, some anywhere.
   function automatic logic [COL_W-1:0] pick_column();
      int unsigned edge_col;
      edge_col = live_columns - 1 + $urandom_range(1);
      if (edge_col > COLUMNS - 1) edge_col = COLUMNS - 1;
      case ($urandom_range(9)) inside
         [0:6]:   return COL_W'($urandom_range(7));
         7:       return COL_W'(edge_col);
         default: return COL_W'($urandom_range(COLUMNS - 1));
      endcase
   endfunction

   // Offers one item and returns at the falling edge after it is taken.
   task automatic offer(input zone_item_type it, input logic typed,
                        input zone_answer_type ans);
      logic [czmp_pkg::REQ_TDATA_W-1:0] d;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      d = '0;
      d[czmp_pkg::REQ_COL_LO +: COL_W] = it.column;
      d[czmp_pkg::REQ_A_LO +: VALUE_W] = it.a;
      d[czmp_pkg::REQ_B_LO +: VALUE_W] = it.b;
      d[czmp_pkg::REQ_OP_LO +: OP_W]   = it.op;
      d[czmp_pkg::REQ_NUM_BIT]         = it.numeric;
      drive_item   = it;
      drive_typed  = typed;
      drive_answer = ans;
      req_tdata  <= d;
      req_tuser  <= it.func;
      req_tlast  <= it.last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stops offering until every expected result is back and the block is quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_columns(input logic [CFG_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random stream: value and null records, tests, and IN lists with random content.
   task automatic run_random(input int unsigned count);
      zone_item_type    it;
      logic [COL_W-1:0] list_col;
      int unsigned      done, roll, n, k;
      done = 0;
      while (done < count) begin
         roll       = $urandom_range(99);
         it.column  = pick_column();
         it.a       = pick_value();
         it.b       = {$urandom, $urandom};
         it.op      = OP_W'($urandom_range(15));
         it.numeric = ($urandom_range(99) < 92);
         it.last    = 1'($urandom_range(1));
         if (roll < 45) begin
            it.func = (roll < 35) ? czmp_pkg::FUNC_VALUE : czmp_pkg::FUNC_NULL;
            // Nulls lean on a block of columns that rarely sees values.
            if (it.func == czmp_pkg::FUNC_NULL && $urandom_range(1))
               it.column = COL_W'($urandom_range(40, 47));
            done++;
            offer(it, 1'b0, ANS_PREDICT);
         end else if (roll < 80) begin
            it.func = czmp_pkg::FUNC_TEST;
            it.a    = pick_target(it.column);
            it.b    = $urandom_range(1) ? pick_target(it.column) : pick_value();
            done++;
            offer(it, 1'b0, ANS_PREDICT);
         end else begin
            n        = $urandom_range(1, 4);
            list_col = it.column;
            for (k = 0; k < n; k++) begin
               it.func    = czmp_pkg::FUNC_ELEM;
               it.column  = ($urandom_range(9) == 0) ? pick_column() : list_col;
               it.a       = pick_target(it.column);
               it.b       = {$urandom, $urandom};
               it.numeric = ($urandom_range(99) < 92);
               it.op      = OP_W'($urandom_range(15));
               it.last    = 1'b0;
               if (k == n - 1) begin
                  roll = $urandom_range(9);
                  if (roll < 7) it.op = czmp_pkg::OP_IN;
                  else if (roll < 9) it.op = OP_NOT_IN;
                  // Some lists run on into the next one without an end mark.
                  it.last = ($urandom_range(9) != 0);
               end
               done++;
               offer(it, 1'b0, ANS_PREDICT);
            end
         end
      end
   endtask

   // Receiver: random stalls, or a long hold-off when one has been requested.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Predict on every accepted item and check every accepted result.
   always @(posedge clock) begin
      zone_answer_type got, want;
      if (!reset) begin
         if (csr_valid && csr_ready) live_columns = csr_data;
         if (req_tvalid && req_tready) begin
            want = zone_apply(drive_item);
            if (drive_typed) want = drive_answer;
            expected_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.verdict = rsp_tdata[czmp_pkg::RSP_VERDICT_BIT];
            got.skip    = rsp_tdata[czmp_pkg::RSP_SKIP_BIT];
            got.dirty   = rsp_tdata[czmp_pkg::RSP_DIRTY_BIT];
            if (expected_q.size() == 0) begin
               $error("result item with no expectation waiting: %b", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.verdict !== want.verdict) begin
                  $error("verdict_valid: expected %0b, actual %0b", want.verdict, got.verdict);
                  fail_count++;
               end
               if (got.skip !== want.skip) begin
                  $error("can_skip: expected %0b, actual %0b", want.skip, got.skip);
                  fail_count++;
               end
               if (got.dirty !== want.dirty) begin
                  $error("dirty: expected %0b, actual %0b", want.dirty, got.dirty);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("column_zone_map_pruner_tb failed");
         $finish;
      end
   end

   initial begin
      int unsigned i, seg, per_seg;
      for (i = 0; i < COLUMNS; i++) begin
         zone_min[i]    = czmp_pkg::VALUE_MAX;
         zone_max[i]    = czmp_pkg::VALUE_MIN;
         zone_sum[i]    = '0;
         value_count[i] = '0;
         null_tally[i]  = '0;
         null_flag[i]   = 1'b0;
      end
      send_idle_pct = 22;
      recv_idle_pct = 65;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows; the clearing pass holds them off until it is done.
      for (i = 0; i < DIR_N; i++) offer(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].answer);
      settle();

      per_seg = (ITEM_TARGET - DIR_N) / SEGMENTS;
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0:       begin send_idle_pct = 22; recv_idle_pct = 65; end
            1:       begin send_idle_pct = 65; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         case (seg)
            0:       write_columns(7'd1);
            1:       write_columns(czmp_pkg::CFG_RESET);
            2:       write_columns(CFG_W'($urandom_range(2, 63)));
            3:       write_columns(CFG_W'($urandom_range(2, 16)));
            4:       write_columns(CFG_W'($urandom_range(1, 64)));
            default: write_columns(czmp_pkg::CFG_RESET);
         endcase
         if (seg == 4) begin
            // Long receiver hold-off while the sender keeps pushing.
            req_tvalid <= 1'b0;
            @(posedge clock);
            hold_requests++;
            @(negedge clock);
         end
         if (seg == 0) begin
            run_random(per_seg / 2);
            settle();
            run_random(per_seg - per_seg / 2);
         end else begin
            run_random(per_seg);
         end
         settle();
      end

      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("column_zone_map_pruner_tb passed");
      end else begin
         $display("column_zone_map_pruner_tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/czmp_pkg.sv
rtl/core/czmp_ram.sv
rtl/core/czmp_ctrl.sv
rtl/core/czmp_datapath.sv
rtl/core/column_zone_map_pruner.sv
rtl/core/czmp_checker.sv
verif/column_zone_map_pruner_tb.sv
